### sv/dur_pkg.sv
// Package with payload types and constants for the duration text parser.
`default_nettype none

package dur_pkg;

    // Width of totals, pending numbers and the cap register.
    localparam int unsigned VAL_W    = 28;
    // Width of a unit scale factor.
    localparam int unsigned FACTOR_W = 25;

    localparam logic [VAL_W-1:0] MAX_TOTAL_RESET = 28'd157680000;
    localparam logic [VAL_W-1:0] VAL_SAT         = 28'hFFFFFFF;

    // ASCII codes of the recognized characters.
    localparam logic [7:0] CHAR_ZERO   = 8'h30;
    localparam logic [7:0] CHAR_NINE   = 8'h39;
    localparam logic [7:0] CHAR_MINUTE = 8'h6D; // m
    localparam logic [7:0] CHAR_HOUR   = 8'h68; // h
    localparam logic [7:0] CHAR_DAY    = 8'h64; // d
    localparam logic [7:0] CHAR_WEEK   = 8'h77; // w
    localparam logic [7:0] CHAR_MONTH  = 8'h4D; // M
    localparam logic [7:0] CHAR_YEAR   = 8'h79; // y

    // Seconds per unit.
    localparam logic [FACTOR_W-1:0] SEC_MINUTE = 25'd60;
    localparam logic [FACTOR_W-1:0] SEC_HOUR   = 25'd3600;
    localparam logic [FACTOR_W-1:0] SEC_DAY    = 25'd86400;
    localparam logic [FACTOR_W-1:0] SEC_WEEK   = 25'd604800;
    localparam logic [FACTOR_W-1:0] SEC_MONTH  = 25'd2620800;
    localparam logic [FACTOR_W-1:0] SEC_YEAR   = 25'd31449600;
    localparam logic [FACTOR_W-1:0] SEC_ONE    = 25'd1;

    // Largest count that a unit still scales. Minutes and hours are
    // exclusive limits, the others inclusive.
    localparam logic [VAL_W-1:0] LIM_MINUTE = 28'd2628000;
    localparam logic [VAL_W-1:0] LIM_HOUR   = 28'd43800;
    localparam logic [VAL_W-1:0] LIM_DAY    = 28'd1900;
    localparam logic [VAL_W-1:0] LIM_WEEK   = 28'd275;
    localparam logic [VAL_W-1:0] LIM_MONTH  = 28'd60;
    localparam logic [VAL_W-1:0] LIM_YEAR   = 28'd5;

    // One byte of duration text.
    typedef struct packed {
        logic [7:0] char_code;
        logic       last;
    } dur_in_t;

    // One parsed total.
    typedef struct packed {
        logic [VAL_W-1:0] total_seconds;
        logic             capped;
    } dur_out_t;

endpackage

`default_nettype wire

### sv/duration_string_parser_core.sv
// Top level of the duration text parser: byte stream in, total in seconds out.
//
// The input channel (s_valid, s_ready, s_data) carries one byte of duration
// text per transfer, with a flag on the final byte of each text. The result
// channel (m_valid, m_ready, m_data) carries one total per text, saturated at
// the max_total register, together with a cap flag.
// The cap register is written through cfg_wr_en / cfg_wr_data; the user must
// write it only while no text is in flight; the block does not enforce this.
// It resets to 157680000 seconds. Bytes are registered on entry and handled
// from the input register; totals leave through the output register. One
// byte per cycle is taken unless a final byte waits on a stalled receiver;
// the rate is set by the single pass through the digit accumulator, unit
// scaling multiplier and saturating adder, which carries the parse state
// from one byte to the next. Reset (aresetn low at a clock edge) empties
// both registers and clears the pending number, running total and cap flag.
// When the receiver stalls, the finished total stays in the output register;
// bytes that do not end a text keep flowing, and a final byte waits in the
// input register until the output register frees up.
`default_nettype none

module duration_string_parser_core (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              cfg_wr_en,
    input  wire logic [27:0]       cfg_wr_data,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire dur_pkg::dur_in_t  s_data,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output dur_pkg::dur_out_t      m_data
);

    import dur_pkg::*;

    logic                   in_valid_reg, in_valid_next;
    dur_in_t                in_data_reg, in_data_next;
    logic                   m_valid_reg, m_valid_next;
    dur_out_t               m_data_reg, m_data_next;
    logic [VAL_W-1:0]       max_total_reg;
    logic [VAL_W-1:0]       pending_reg, pending_next;
    logic [VAL_W-1:0]       total_reg, total_next;
    logic                   cap_reg, cap_next;
    logic                   in_number_reg, in_number_next;

    logic                   advance;
    logic                   is_digit;
    logic [3:0]             digit_val;
    logic [VAL_W+3:0]       accum_wide;
    logic [VAL_W-1:0]       accum_sat;
    logic [FACTOR_W-1:0]    factor;
    logic [VAL_W+FACTOR_W-1:0] product;
    logic [VAL_W-1:0]       add_amount;
    logic                   add_en;
    logic [VAL_W:0]         sum;
    logic [VAL_W-1:0]       total_upd;
    logic                   cap_upd;

    // The stage moves when it holds a byte that is not final, or a final byte
    // with room to leave its total in the output register.
    assign advance = in_valid_reg &&
                     (!in_data_reg.last || !m_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Digit accumulation: pending * 10 + digit, saturated to the field width.
    assign is_digit   = (in_data_reg.char_code >= CHAR_ZERO) &&
                        (in_data_reg.char_code <= CHAR_NINE);
    assign digit_val  = 4'(in_data_reg.char_code - CHAR_ZERO);
    assign accum_wide = ({4'b0, pending_reg} << 3) + ({4'b0, pending_reg} << 1) +
                        {{VAL_W{1'b0}}, digit_val};
    assign accum_sat  = (accum_wide > {4'b0, VAL_SAT}) ? VAL_SAT
                                                      : accum_wide[VAL_W-1:0];

    // Unit selection: a unit scales only when the count is within its limit.
    always_comb begin
        factor = SEC_ONE;
        unique case (in_data_reg.char_code)
            CHAR_MINUTE: if (pending_reg <  LIM_MINUTE) factor = SEC_MINUTE;
            CHAR_HOUR:   if (pending_reg <  LIM_HOUR)   factor = SEC_HOUR;
            CHAR_DAY:    if (pending_reg <= LIM_DAY)    factor = SEC_DAY;
            CHAR_WEEK:   if (pending_reg <= LIM_WEEK)   factor = SEC_WEEK;
            CHAR_MONTH:  if (pending_reg <= LIM_MONTH)  factor = SEC_MONTH;
            CHAR_YEAR:   if (pending_reg <= LIM_YEAR)   factor = SEC_YEAR;
            default:     factor = SEC_ONE;
        endcase
    end

    // Every in-limit product stays below 2^28, so the low bits are exact.
    assign product = pending_reg * factor;

    // Parse step: decide what, if anything, this byte adds to the total.
    always_comb begin
        pending_next   = pending_reg;
        in_number_next = in_number_reg;
        add_amount     = '0;
        add_en         = 1'b0;
        if (advance && !cap_reg) begin
            if (is_digit) begin
                if (in_data_reg.last) begin
                    add_amount     = accum_sat;
                    add_en         = 1'b1;
                    pending_next   = '0;
                    in_number_next = 1'b0;
                end else begin
                    pending_next   = accum_sat;
                    in_number_next = 1'b1;
                end
            end else if (in_number_reg) begin
                add_amount     = product[VAL_W-1:0];
                add_en         = 1'b1;
                pending_next   = '0;
                in_number_next = 1'b0;
            end
        end
    end

    // Saturating add into the running total; a zero amount adds nothing.
    assign sum = {1'b0, total_reg} + {1'b0, add_amount};
    always_comb begin
        total_upd = total_reg;
        cap_upd   = cap_reg;
        if (add_en && (add_amount != '0)) begin
            if (sum >= {1'b0, max_total_reg}) begin
                total_upd = max_total_reg;
                cap_upd   = 1'b1;
            end else begin
                total_upd = sum[VAL_W-1:0];
            end
        end
    end

    // End of text: emit the total and return the parse state to reset.
    always_comb begin
        total_next   = total_upd;
        cap_next     = cap_upd;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        if (advance && in_data_reg.last) begin
            m_valid_next              = 1'b1;
            m_data_next.total_seconds = total_upd;
            m_data_next.capped        = cap_upd;
            total_next                = '0;
            cap_next                  = 1'b0;
        end
    end

    // Input register loads on every transfer.
    always_comb begin
        in_valid_next = in_valid_reg && !advance;
        in_data_next  = in_data_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
            in_data_next  = s_data;
        end
    end

    // Control and parse state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            m_valid_reg   <= 1'b0;
            max_total_reg <= MAX_TOTAL_RESET;
            pending_reg   <= '0;
            total_reg     <= '0;
            cap_reg       <= 1'b0;
            in_number_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            m_valid_reg   <= m_valid_next;
            pending_reg   <= pending_next;
            total_reg     <= total_next;
            cap_reg       <= cap_next;
            in_number_reg <= in_number_next;
            if (cfg_wr_en) begin
                max_total_reg <= cfg_wr_data;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        in_data_reg <= in_data_next;
        m_data_reg  <= m_data_next;
    end

    // Without a number in progress nothing may be pending.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !in_number_reg |-> (pending_reg == '0))
        else $error("pending number held outside a number");

    // An empty input register always takes a transfer.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !in_valid_reg |-> s_ready)
        else $error("input register empty but not ready");

    // A final byte leaves the parse state cleared for the next text.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && in_data_reg.last) |=>
            (!in_number_reg && !cap_reg && (total_reg == '0) && m_valid_reg))
        else $error("parse state not cleared after final byte");

endmodule

`default_nettype wire
